FILE: rtl/tgr_pkg.sv
// Package for the text glyph row generator: operation and source codes,
// the built-in graphics table, the marker glyph and the screen-code map.
// No dependencies.
package tgr_pkg;

   localparam int BASE_GLYPHS  = 64;
   localparam int GLYPH_ROWS   = 8;
   localparam int STORE_DEPTH  = BASE_GLYPHS * GLYPH_ROWS;
   localparam int STORE_AW     = $clog2(STORE_DEPTH);
   localparam int GLYPH_AW     = $clog2(BASE_GLYPHS);
   localparam int ROW_W        = $clog2(GLYPH_ROWS);

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      SRC_BUILTIN = 2'd0,
      SRC_BASE    = 2'd1,
      SRC_MARKER  = 2'd2
   } glyph_src_type;

   // strobes from the handshake logic into the glyph unit
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } tgr_ctl_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] pixels;
   } builtin_type;

   typedef struct packed {
      logic                hit;
      logic [GLYPH_AW-1:0] glyph;
   } map_type;

   localparam logic [63:0] HOLLOW_GLYPH = 64'h007E_4242_4242_7E00;

   // byte of an eight-row glyph, top row in the most significant byte
   function automatic logic [7:0] glyph_byte(input logic [63:0] rows,
                                             input logic [ROW_W-1:0] row);
      logic [5:0] base;
      base = {~row, 3'b000};
      return rows[base +: 8];
   endfunction

   function automatic builtin_type builtin_lookup(input logic [6:0] code,
                                                  input logic [ROW_W-1:0] row);
      builtin_type r;
      logic [63:0] rows;
      r.hit = 1'b1;
      rows  = '0;
      case (code)
         7'd32:   rows = 64'h0000_0000_0000_0000;
         7'd64:   rows = 64'h0000_00FF_FF00_0000;
         7'd93:   rows = 64'h1818_1818_1818_1818;
         7'd112:  rows = 64'h0000_001F_1F18_1818;
         7'd110:  rows = 64'h0000_00F8_F818_1818;
         7'd109:  rows = 64'h1818_181F_1F00_0000;
         7'd125:  rows = 64'h1818_18F8_F800_0000;
         7'd107:  rows = 64'h1818_181F_1F18_1818;
         7'd115:  rows = 64'h1818_18F8_F818_1818;
         7'd114:  rows = 64'h0000_00FF_FF18_1818;
         7'd113:  rows = 64'h1818_18FF_FF00_0000;
         7'd91:   rows = 64'h1818_18FF_FF18_1818;
         7'd98:   rows = 64'h0000_0000_FFFF_FFFF;
         7'd100:  rows = 64'h0000_0000_0000_00FF;
         7'd30:   rows = 64'h183C_7E18_1818_1800;
         7'd31:   rows = 64'h0010_307E_3010_0000;
         7'd81:   rows = 64'h003C_7EFF_FF7E_3C00;
         default: r.hit = 1'b0;
      endcase
      r.pixels = glyph_byte(rows, row);
      return r;
   endfunction

   // screen code to base font glyph (ASCII minus 0x20)
   function automatic map_type screen_map(input logic [6:0] code);
      map_type m;
      m.hit   = 1'b1;
      m.glyph = '0;
      case (code) inside
         [7'd0:7'd26]:  m.glyph = GLYPH_AW'(code + 7'h20);
         7'd27:         m.glyph = GLYPH_AW'(7'h3B);
         7'd29:         m.glyph = GLYPH_AW'(7'h3D);
         [7'd32:7'd63]: m.glyph = GLYPH_AW'(code - 7'h20);
         default:       m.hit = 1'b0;
      endcase
      return m;
   endfunction

endpackage

FILE: rtl/tgr_glyph_unit.sv
// Glyph unit: base font store (synchronous RAM, registered read) plus the
// built-in table and marker lookup, registered alongside the RAM read.
// Depends on tgr_pkg.
module tgr_glyph_unit (
   input  logic                         clock,
   input  tgr_pkg::tgr_ctl_type         ctl,
   input  logic [tgr_pkg::STORE_AW-1:0] font_index,
   input  logic [7:0]                   font_byte,
   input  logic [7:0]                   screen_code,
   input  logic [tgr_pkg::ROW_W-1:0]    glyph_row,
   output logic [7:0]                   pixel_row,
   output tgr_pkg::glyph_src_type       glyph_source
);

   logic [7:0] font_mem [tgr_pkg::STORE_DEPTH];

   logic [7:0]             rd_data_ff;
   logic [7:0]             fixed_ff, fixed_in;
   logic                   inv_ff;
   tgr_pkg::glyph_src_type src_ff, src_in;

   tgr_pkg::builtin_type         bi;
   tgr_pkg::map_type             mp;
   logic [tgr_pkg::STORE_AW-1:0] rd_addr;

   always_comb begin
      bi      = tgr_pkg::builtin_lookup(screen_code[6:0], glyph_row);
      mp      = tgr_pkg::screen_map(screen_code[6:0]);
      rd_addr = {mp.glyph, glyph_row};
      if (bi.hit) begin
         src_in   = tgr_pkg::SRC_BUILTIN;
         fixed_in = bi.pixels;
      end else if (mp.hit) begin
         src_in   = tgr_pkg::SRC_BASE;
         fixed_in = '0;
      end else begin
         src_in   = tgr_pkg::SRC_MARKER;
         fixed_in = tgr_pkg::glyph_byte(tgr_pkg::HOLLOW_GLYPH, glyph_row);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         font_mem[font_index] <= font_byte;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= font_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         fixed_ff <= fixed_in;
         src_ff   <= src_in;
         inv_ff   <= screen_code[7];
      end
   end

   assign pixel_row    = ((src_ff == tgr_pkg::SRC_BASE) ? rd_data_ff : fixed_ff)
                         ^ {8{inv_ff}};
   assign glyph_source = src_ff;

endmodule

FILE: rtl/text_glyph_row_generator.sv
// Top level of the text glyph row generator: word handshakes, lookup stage
// and output register around the glyph unit.
// Depends on tgr_pkg and tgr_glyph_unit.
//
//   channel | ports                                   | direction
//   req     | req_valid, req_stall, req_* fields      | in  (load or lookup word)
//   rsp     | rsp_valid, rsp_stall, rsp_* fields      | out (one word per lookup)
//
// One word accepted per cycle while req_stall is low; a lookup result passes through
// the font RAM read register, then the output register. Loads give no result word.
// Reset (synchronous) clears the valid flags only; the font RAM is not cleared.
// A stalled rsp word holds; req stalls only when the lookup stage is occupied
// and the output register holds a word under rsp_stall.
module text_glyph_row_generator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_operation,
   input  logic [8:0] req_font_index,
   input  logic [7:0] req_font_byte,
   input  logic [7:0] req_screen_code,
   input  logic [2:0] req_glyph_row,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_pixel_row,
   output logic [1:0] rsp_glyph_source
);

   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] pix_ff;
   logic [1:0] src_ff;

   logic                   accept;
   logic                   advance;
   tgr_pkg::tgr_ctl_type   ctl;
   logic [7:0]             unit_pixels;
   tgr_pkg::glyph_src_type unit_src;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      ctl.wr_en = accept && (req_operation == tgr_pkg::OP_LOAD);
      ctl.rd_en = accept && (req_operation == tgr_pkg::OP_LOOKUP);
   end

   always_comb begin
      if (ctl.rd_en) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   tgr_glyph_unit u_glyph (
      .clock        (clock),
      .ctl          (ctl),
      .font_index   (req_font_index),
      .font_byte    (req_font_byte),
      .screen_code  (req_screen_code),
      .glyph_row    (req_glyph_row),
      .pixel_row    (unit_pixels),
      .glyph_source (unit_src)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pix_ff <= unit_pixels;
         src_ff <= 2'(unit_src);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_row    = pix_ff;
   assign rsp_glyph_source = src_ff;

endmodule
